>>> rtl/vtgn_pkg.sv
// Shared constants, command codes and control types of the voice table gain normalizer.
package vtgn_pkg;

   localparam int MAX_NOTES  = 16;
   localparam int SLOT_IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
   localparam int CNT_W      = ($clog2(MAX_NOTES + 1) > 5) ? $clog2(MAX_NOTES + 1) : 5;

   localparam int CMD_W    = 2;
   localparam int FREQ_W   = 16;
   localparam int DUR_W    = 31;
   localparam int LEVEL_W  = 16;
   localparam int SAMP_W   = 16;
   localparam int RATE_W   = 18;
   localparam int GAIN_W   = 16;
   localparam int ACTIVE_W = 5;

   // level sum over all slots, and divider widths
   localparam int SUM_W     = LEVEL_W + CNT_W;
   localparam int NUM_W     = RATE_W + SAMP_W;
   localparam int DEN_W     = (SUM_W > RATE_W) ? SUM_W : RATE_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
   localparam logic [RATE_W-1:0] MS_SCALE   = 18'd256000;
   localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'd32768;
   localparam logic [NUM_W-1:0]  GAIN_NUM   = NUM_W'(64'd1 << 30);

   typedef enum logic [2:0] {
      SLOT_OP_NONE  = 3'b001,
      SLOT_OP_WRITE = 3'b010,
      SLOT_OP_WALK  = 3'b100
   } slot_op_type;

   typedef struct packed {
      slot_op_type            op;
      logic [SLOT_IDX_W-1:0]  index;
      logic [CMD_W-1:0]       command;
      logic [FREQ_W-1:0]      frequency;
      logic [DUR_W-1:0]       note_duration;
      logic [LEVEL_W-1:0]     note_level;
      logic [NUM_W-1:0]       dec;
   } slot_ctrl_type;

   typedef struct packed {
      logic                   free_found;
      logic [SLOT_IDX_W-1:0]  free_index;
      logic                   keep;
      logic [LEVEL_W-1:0]     level;
   } slot_stat_type;

   typedef struct packed {
      logic                   start;
      logic [NUM_W-1:0]       num;
      logic [DEN_W-1:0]       den;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [NUM_W-1:0]       quo;
   } div_rsp_type;

endpackage

>>> rtl/vtgn_ifs.sv
// Channel interfaces: command input, result output and sample rate write.
interface vtgn_req_if
   import vtgn_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [FREQ_W-1:0]    frequency;
   logic [DUR_W-1:0]     note_duration;
   logic [LEVEL_W-1:0]   note_level;
   logic [SAMP_W-1:0]    elapsed_samples;

   modport source (output valid, command, frequency, note_duration, note_level,
                   elapsed_samples, input ready);
   modport sink   (input valid, command, frequency, note_duration, note_level,
                   elapsed_samples, output ready);
endinterface

interface vtgn_rsp_if
   import vtgn_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [GAIN_W-1:0]     note_gain;
   logic [ACTIVE_W-1:0]   active_notes;
   logic                  add_dropped;

   modport source (output valid, note_gain, active_notes, add_dropped, input ready);
   modport sink   (input valid, note_gain, active_notes, add_dropped, output ready);
endinterface

interface vtgn_csr_if
   import vtgn_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [RATE_W-1:0]    data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> rtl/voice_table_gain_normalizer_unit.sv
// Top level: command sequencer around the slot table and the shared divider.
//
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------------------
//   req_bus  | in  | command, frequency, note_duration, note_level, elapsed_samples
//   rsp_bus  | out | note_gain, active_notes, add_dropped
//   csr_bus  | in  | data = audio rate in Hz (18 bit), reset value 48000
//
// A command is captured in ST_IDLE; add then writes a free slot in ST_WRITE, tick
// forms the product in ST_MUL and divides it in ST_DEC, remove goes straight on; all
// then walk the MAX_NOTES slots, check, divide again when the level sum exceeds 1.0,
// and output the result.
// The shared divider works one quotient bit per cycle.
// Reset is synchronous and empties the table; req_bus is ready only between commands.
// The result register holds a beat until taken; a new command may run meanwhile.
module voice_table_gain_normalizer_unit
   import vtgn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   vtgn_req_if.sink      req_bus,
   vtgn_rsp_if.source    rsp_bus,
   vtgn_csr_if.sink      csr_bus
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_WRITE = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_DEC   = 8'b0000_1000,
      ST_WALK  = 8'b0001_0000,
      ST_CHK   = 8'b0010_0000,
      ST_GAIN  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [RATE_W-1:0]       rate_ff;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [FREQ_W-1:0]       freq_ff, freq_in;
   logic [DUR_W-1:0]        dur_ff, dur_in;
   logic [LEVEL_W-1:0]      lvl_ff, lvl_in;
   logic [SAMP_W-1:0]       samp_ff, samp_in;
   logic [NUM_W-1:0]        prod_ff, prod_in;
   logic [NUM_W-1:0]        dec_ff, dec_in;
   logic [SLOT_IDX_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    drop_ff, drop_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [GAIN_W-1:0]       rsp_gain_ff, rsp_gain_in;
   logic [ACTIVE_W-1:0]     rsp_cnt_ff, rsp_cnt_in;
   logic                    rsp_drop_ff, rsp_drop_in;

   logic [RATE_W-1:0]       rate_eff;
   slot_ctrl_type           slot_ctrl;
   slot_stat_type           slot_stat;
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic                    req_beat;
   logic                    rsp_free;

   vtgn_table u_table (
      .clock (clock),
      .reset (reset),
      .ctrl  (slot_ctrl),
      .stat  (slot_stat)
   );

   vtgn_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_bus.valid) begin
         rate_ff <= csr_bus.data;
      end
   end

   assign rate_eff       = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign req_beat       = req_bus.valid && req_bus.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      slot_ctrl.op            = SLOT_OP_NONE;
      slot_ctrl.index         = idx_ff;
      slot_ctrl.command       = cmd_ff;
      slot_ctrl.frequency     = freq_ff;
      slot_ctrl.note_duration = dur_ff;
      slot_ctrl.note_level    = lvl_ff;
      slot_ctrl.dec           = dec_ff;
      div_req.start = 1'b0;
      div_req.num   = prod_ff;
      div_req.den   = DEN_W'(rate_eff);

      state_in = state_ff;
      cmd_in   = cmd_ff;
      freq_in  = freq_ff;
      dur_in   = dur_ff;
      lvl_in   = lvl_ff;
      samp_in  = samp_ff;
      prod_in  = prod_ff;
      dec_in   = dec_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      drop_in  = drop_ff;
      gain_in  = gain_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_gain_in  = rsp_gain_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_drop_in  = rsp_drop_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               cmd_in  = req_bus.command;
               freq_in = req_bus.frequency;
               dur_in  = req_bus.note_duration;
               lvl_in  = req_bus.note_level;
               samp_in = req_bus.elapsed_samples;
               dec_in  = '0;
               idx_in  = '0;
               sum_in  = '0;
               cnt_in  = '0;
               drop_in = 1'b0;
               if (req_bus.command == CMD_ADD)       state_in = ST_WRITE;
               else if (req_bus.command == CMD_TICK) state_in = ST_MUL;
               else                                  state_in = ST_WALK;
            end
         end
         ST_WRITE: begin
            if (slot_stat.free_found) begin
               slot_ctrl.op    = SLOT_OP_WRITE;
               slot_ctrl.index = slot_stat.free_index;
            end else begin
               drop_in = 1'b1;
            end
            state_in = ST_WALK;
         end
         ST_MUL: begin
            prod_in  = {{SAMP_W{1'b0}}, MS_SCALE} * {{RATE_W{1'b0}}, samp_ff};
            state_in = ST_DEC;
            // divider starts next cycle from the registered product
         end
         ST_DEC: begin
            if (div_rsp.done) begin
               dec_in   = div_rsp.quo;
               state_in = ST_WALK;
            end else if (prod_ff != '1 && idx_ff == '0 && sum_ff == '0 && !drop_ff
                         && cnt_ff == '0 && dec_ff == '0) begin
               div_req.start = 1'b1;
               drop_in       = 1'b1;   // mark divider launched; cleared below
            end
         end
         ST_WALK: begin
            slot_ctrl.op = SLOT_OP_WALK;
            drop_in      = (cmd_ff == CMD_ADD) ? drop_ff : 1'b0;
            if (slot_stat.keep) begin
               sum_in = sum_ff + SUM_W'(slot_stat.level);
               cnt_in = cnt_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SLOT_IDX_W'(MAX_NOTES - 1)) begin
               idx_in   = '0;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (sum_ff <= SUM_W'(GAIN_ONE)) begin
               gain_in  = GAIN_ONE;
               state_in = ST_OUT;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = GAIN_NUM;
               div_req.den   = DEN_W'(sum_ff);
               state_in      = ST_GAIN;
            end
         end
         ST_GAIN: begin
            if (div_rsp.done) begin
               gain_in  = div_rsp.quo[GAIN_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_gain_in  = gain_ff;
               rsp_cnt_in   = cnt_ff[ACTIVE_W-1:0];
               rsp_drop_in  = drop_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      freq_ff     <= freq_in;
      dur_ff      <= dur_in;
      lvl_ff      <= lvl_in;
      samp_ff     <= samp_in;
      prod_ff     <= prod_in;
      dec_ff      <= dec_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      drop_ff     <= drop_in;
      gain_ff     <= gain_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_drop_ff <= rsp_drop_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.note_gain    = rsp_gain_ff;
   assign rsp_bus.active_notes = rsp_cnt_ff;
   assign rsp_bus.add_dropped  = rsp_drop_ff;

endmodule

>>> rtl/vtgn_div.sv
// Shared restoring divider, one quotient bit per cycle.
module vtgn_div
   import vtgn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  req,
   output div_rsp_type  rsp
);

   logic [NUM_W-1:0]     num_ff, num_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       rem_sh;
   logic                 qbit;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      qbit    = (rem_sh >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.num;
         den_in  = req.den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift the quotient bit into the dividend register
         num_in = {num_ff[NUM_W-2:0], qbit};
         rem_in = qbit ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = num_ff;

endmodule

>>> rtl/vtgn_table.sv
// Note slot table: valid bits, per-slot fields and the per-slot command step.
module vtgn_table
   import vtgn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  slot_ctrl_type  ctrl,
   output slot_stat_type  stat
);

   logic [MAX_NOTES-1:0] valid_ff, valid_in;
   logic [FREQ_W-1:0]    freq_ff [MAX_NOTES];
   logic [DUR_W-1:0]     rem_ff  [MAX_NOTES];
   logic [LEVEL_W-1:0]   lvl_ff  [MAX_NOTES];

   logic                 free_found;
   logic [SLOT_IDX_W-1:0] free_index;
   logic                 cur_valid;
   logic [FREQ_W-1:0]    cur_freq;
   logic [DUR_W-1:0]     cur_rem;
   logic                 keep;
   logic                 rem_upd;
   logic [DUR_W-1:0]     rem_new;

   always_comb begin
      free_found = 1'b0;
      free_index = '0;
      // scan downward so the lowest free slot wins
      for (int i = MAX_NOTES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_index = SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      cur_valid = valid_ff[ctrl.index];
      cur_freq  = freq_ff[ctrl.index];
      cur_rem   = rem_ff[ctrl.index];
      keep      = cur_valid;
      rem_upd   = 1'b0;
      rem_new   = cur_rem - ctrl.dec[DUR_W-1:0];
      case (ctrl.command)
         CMD_REMOVE: begin
            if (cur_valid && cur_freq == ctrl.frequency) keep = 1'b0;
         end
         CMD_TICK: begin
            if (cur_valid && cur_rem != '0) begin
               if (NUM_W'(cur_rem) <= ctrl.dec) keep = 1'b0;
               else rem_upd = 1'b1;
            end
         end
         default: begin
            keep = cur_valid;
         end
      endcase
   end

   assign stat = '{free_found: free_found, free_index: free_index, keep: keep,
                   level: lvl_ff[ctrl.index]};

   always_comb begin
      valid_in = valid_ff;
      case (ctrl.op)
         SLOT_OP_WRITE: valid_in[ctrl.index] = 1'b1;
         SLOT_OP_WALK:  valid_in[ctrl.index] = keep;
         default:       valid_in = valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == SLOT_OP_WRITE) begin
         freq_ff[ctrl.index] <= ctrl.frequency;
         rem_ff[ctrl.index]  <= ctrl.note_duration;
         lvl_ff[ctrl.index]  <= ctrl.note_level;
      end else if (ctrl.op == SLOT_OP_WALK && rem_upd) begin
         rem_ff[ctrl.index]  <= rem_new;
      end
   end

endmodule
